@@ hdl/mxn_pkg.sv @@
package mxn_pkg;

    localparam int MAX_NODES  = 16;
    localparam int EFF_MAX    = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int QDEPTH     = 15;
    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_REQUEST_CS  = 2'd0,
        OP_RELEASE_CS  = 2'd1,
        OP_RECV_REQUEST = 2'd2,
        OP_RECV_REPLY  = 2'd3
    } mxn_op_t;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_ENTER   = 2'd2,
        KIND_REJECT  = 2'd3
    } mxn_kind_t;

    typedef enum logic [1:0] {
        NODE_IDLE       = 2'd0,
        NODE_REQUESTING = 2'd1,
        NODE_IN_CS      = 2'd2
    } mxn_node_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_DECIDE = 2'd1,
        FSM_EMIT   = 2'd2
    } mxn_fsm_t;

    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_ONE  = 2'd1,
        DEC_LOOP = 2'd2
    } mxn_dec_t;

    typedef enum logic {
        REG_NODE_ID    = 1'b0,
        REG_NODE_COUNT = 1'b1
    } mxn_reg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  peer;
        logic [31:0] timestamp;
    } mxn_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  destination;
        logic [31:0] stamp;
        logic        last;
    } mxn_out_t;

    typedef struct packed {
        logic load_in;
        logic decide;
        logic step;
    } mxn_cmd_t;

    typedef struct packed {
        mxn_dec_t dec;
        logic     out_free;
        logic     at_self;
        logic     at_last;
    } mxn_sts_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ hdl/mxn_ctrl.sv @@
module mxn_ctrl
    import mxn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mxn_sts_t sts,
    output mxn_cmd_t cmd
);

    mxn_fsm_t state_reg;
    mxn_fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = FSM_DECIDE;
                end
            end
            FSM_DECIDE: begin
                if (sts.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = (sts.dec == DEC_LOOP) ? FSM_EMIT : FSM_IDLE;
                end
            end
            FSM_EMIT: begin
                if (sts.at_self) begin
                    cmd.step = 1'b1;
                end else if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.at_last) begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/mxn_dp.sv @@
module mxn_dp
    import mxn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mxn_cmd_t   cmd,
    output mxn_sts_t   sts,
    input  logic [3:0] node_id,
    input  logic [4:0] node_count,
    input  mxn_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output mxn_out_t   m_data
);

    mxn_in_t         in_reg;
    logic [31:0]     clock_reg,     clock_next;
    mxn_node_state_t nstate_reg,    nstate_next;
    logic [31:0]     req_stamp_reg, req_stamp_next;
    logic [3:0]      reply_cnt_reg, reply_cnt_next;
    logic [3:0]      dcount_reg,    dcount_next;
    logic [3:0]      idx_reg,       idx_next;
    logic            m_valid_reg,   m_valid_next;
    mxn_out_t        m_data_reg,    m_data_next;
    logic [3:0]      queue_reg [QDEPTH];
    logic            q_we;

    logic [4:0]  n_eff;
    logic [4:0]  id_ext;
    logic [4:0]  last_req_idx;
    logic [31:0] clk_base;
    logic [31:0] clk_upd;
    logic [3:0]  rc_inc;
    logic        bad_peer;
    logic        rej_pre;
    logic        complete;
    logic        prio;
    logic        grant;
    logic        q_full;
    logic        is_req_loop;
    logic        out_free;
    mxn_dec_t    dec;
    mxn_out_t    one_item;
    mxn_out_t    loop_item;

    assign id_ext   = {1'b0, node_id};
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (node_count < 5'd2) begin
            n_eff = 5'd2;
        end else if (node_count > 5'(EFF_MAX)) begin
            n_eff = 5'(EFF_MAX);
        end else begin
            n_eff = node_count;
        end
    end

    assign clk_base = (in_reg.operation[1] && (in_reg.timestamp > clock_reg)) ?
                      in_reg.timestamp : clock_reg;
    assign clk_upd  = sat_inc(clk_base);
    assign rc_inc   = reply_cnt_reg + 4'd1;
    assign complete = {1'b0, rc_inc} >= (n_eff - 5'd1);
    assign bad_peer = (in_reg.peer == node_id) || ({1'b0, in_reg.peer} >= n_eff);
    assign prio     = (in_reg.timestamp < req_stamp_reg) ||
                      ((in_reg.timestamp == req_stamp_reg) && (in_reg.peer < node_id));
    assign grant    = (nstate_reg == NODE_IDLE) ||
                      ((nstate_reg == NODE_REQUESTING) && prio);
    assign q_full   = dcount_reg == 4'(QDEPTH);

    always_comb begin
        unique case (in_reg.operation)
            OP_REQUEST_CS:   rej_pre = (nstate_reg != NODE_IDLE) || (id_ext >= n_eff);
            OP_RELEASE_CS:   rej_pre = nstate_reg != NODE_IN_CS;
            OP_RECV_REQUEST: rej_pre = bad_peer;
            OP_RECV_REPLY:   rej_pre = bad_peer || (nstate_reg != NODE_REQUESTING);
            default:         rej_pre = 1'b1;
        endcase
    end

    // decision and the single result of this item
    always_comb begin
        dec      = DEC_NONE;
        one_item = '{kind: KIND_REJECT, destination: node_id, stamp: clock_reg, last: 1'b1};
        if (!rej_pre) begin
            unique case (in_reg.operation)
                OP_REQUEST_CS: begin
                    dec = DEC_LOOP;
                end
                OP_RELEASE_CS: begin
                    dec = (dcount_reg == 4'd0) ? DEC_NONE : DEC_LOOP;
                end
                OP_RECV_REPLY: begin
                    if (complete) begin
                        dec = DEC_ONE;
                        one_item.kind  = KIND_ENTER;
                        one_item.stamp = clk_upd;
                    end
                end
                OP_RECV_REQUEST: begin
                    if (grant) begin
                        dec = DEC_ONE;
                        one_item.kind        = KIND_REPLY;
                        one_item.destination = in_reg.peer;
                        one_item.stamp       = clk_upd;
                    end else if (q_full) begin
                        dec = DEC_ONE;
                        one_item.stamp = clk_upd;
                    end
                end
                default: begin
                    dec = DEC_NONE;
                end
            endcase
        end else begin
            dec = DEC_ONE;
        end
    end

    // fan-out loop over node ids or queued requesters
    assign is_req_loop  = in_reg.operation == OP_REQUEST_CS;
    assign last_req_idx = (id_ext == n_eff - 5'd1) ? n_eff - 5'd2 : n_eff - 5'd1;

    always_comb begin
        sts.dec      = dec;
        sts.out_free = out_free;
        sts.at_self  = is_req_loop && (idx_reg == node_id);
        sts.at_last  = is_req_loop ? ({1'b0, idx_reg} == last_req_idx) :
                                     (idx_reg == dcount_reg - 4'd1);
    end

    always_comb begin
        loop_item.kind        = is_req_loop ? KIND_REQUEST : KIND_REPLY;
        loop_item.destination = is_req_loop ? idx_reg : queue_reg[idx_reg];
        loop_item.stamp       = clock_reg;
        loop_item.last        = sts.at_last;
    end

    always_comb begin
        clock_next     = clock_reg;
        nstate_next    = nstate_reg;
        req_stamp_next = req_stamp_reg;
        reply_cnt_next = reply_cnt_reg;
        dcount_next    = dcount_reg;
        idx_next       = idx_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        q_we           = 1'b0;

        if (cmd.decide) begin
            idx_next = 4'd0;
            if (dec == DEC_ONE) begin
                m_data_next  = one_item;
                m_valid_next = 1'b1;
            end
            if (!rej_pre) begin
                clock_next = clk_upd;
                unique case (in_reg.operation)
                    OP_REQUEST_CS: begin
                        nstate_next    = NODE_REQUESTING;
                        req_stamp_next = clk_upd;
                        reply_cnt_next = 4'd0;
                    end
                    OP_RELEASE_CS: begin
                        nstate_next = NODE_IDLE;
                    end
                    OP_RECV_REPLY: begin
                        reply_cnt_next = rc_inc;
                        if (complete) begin
                            nstate_next = NODE_IN_CS;
                        end
                    end
                    OP_RECV_REQUEST: begin
                        if (!grant && !q_full) begin
                            q_we        = 1'b1;
                            dcount_next = dcount_reg + 4'd1;
                        end
                    end
                    default: begin
                        clock_next = clk_upd;
                    end
                endcase
            end
        end

        if (cmd.step) begin
            idx_next = idx_reg + 4'd1;
            if (!sts.at_self) begin
                m_data_next  = loop_item;
                m_valid_next = 1'b1;
                if (!is_req_loop && sts.at_last) begin
                    dcount_next = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg     <= '0;
            nstate_reg    <= NODE_IDLE;
            req_stamp_reg <= '0;
            reply_cnt_reg <= '0;
            dcount_reg    <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            clock_reg     <= clock_next;
            nstate_reg    <= nstate_next;
            req_stamp_reg <= req_stamp_next;
            reply_cnt_reg <= reply_cnt_next;
            dcount_reg    <= dcount_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (q_we) begin
            queue_reg[dcount_reg] <= in_reg.peer;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/mutual_exclusion_node_core.sv @@
// flow: an accepted item is registered, then decided once the output is free; a single
//   result goes to the output register, a request or release then emits from EMIT
// received messages: a new item is taken only after the last one is decided, at most one result each
// request: one REQUEST to every other node id below the effective node count
// release: one REPLY per cycle from the deferred fifo while the output is free
// reset: synchronous, active low; clears clock, node state and counters, not the fifo
module mutual_exclusion_node_core
    import mxn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mxn_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mxn_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    logic [3:0] node_id_reg,    node_id_next;
    logic [4:0] node_count_reg, node_count_next;
    mxn_reg_t   reg_sel;
    logic       cfg_wr;
    mxn_cmd_t   cmd;
    mxn_sts_t   sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = mxn_reg_t'(paddr[2]);

    always_comb begin
        node_id_next    = node_id_reg;
        node_count_next = node_count_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_NODE_ID:    node_id_next    = pwdata[3:0];
                REG_NODE_COUNT: node_count_next = pwdata[4:0];
                default:        node_id_next    = node_id_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NODE_ID:    prdata = {{(DATA_WIDTH-4){1'b0}}, node_id_reg};
            REG_NODE_COUNT: prdata = {{(DATA_WIDTH-5){1'b0}}, node_count_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= 4'd0;
            node_count_reg <= 5'd2;
        end else begin
            node_id_reg    <= node_id_next;
            node_count_reg <= node_count_next;
        end
    end

    mxn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mxn_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .node_id    (node_id_reg),
        .node_count (node_count_reg),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
